// File: rtl/sbrf_pkg.sv
`timescale 1ns / 1ps

package sbrf_pkg;

    // Operation codes of a request.
    localparam logic [3:0] OP_VERSION     = 4'd0;
    localparam logic [3:0] OP_INFO_FIRST  = 4'd1;
    localparam logic [3:0] OP_INFO_LAST   = 4'd6;
    localparam logic [3:0] OP_BLOCK_CHANS = 4'd7;
    localparam logic [3:0] OP_CHAN_INFO   = 4'd8;
    localparam logic [3:0] OP_ONLINE_ONE  = 4'd9;
    localparam logic [3:0] OP_ONLINE_MULT = 4'd10;
    localparam logic [3:0] OP_RESET       = 4'd11;
    localparam logic [3:0] OP_STATUS      = 4'd12;
    localparam logic [3:0] OP_ERROR       = 4'd13;

    // Command bytes.
    localparam logic [7:0] CMD_VERSION     = 8'h20;
    localparam logic [7:0] CMD_INFO        = 8'h2D;
    localparam logic [7:0] CMD_ONLINE_ONE  = 8'h23;
    localparam logic [7:0] CMD_ONLINE_MULT = 8'h2F;
    localparam logic [7:0] CMD_RESET       = 8'h25;
    localparam logic [7:0] CMD_STATUS      = 8'h26;
    localparam logic [7:0] CMD_ERROR       = 8'h2C;

    // Frame bytes.
    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] VER_BYTE = 8'h10;

    localparam logic [7:0] INFO_BASE      = 8'h0F;
    localparam logic [7:0] SUB_BLOCK      = 8'h16;
    localparam logic [7:0] SUB_CHAN_INFO  = 8'h30;
    localparam logic [7:0] SUB_RESET      = 8'h10;

    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_START = 16'hFFFF;

    localparam logic [15:0] STATION_RESET = 16'h7001;
    localparam logic [15:0] MASTER_RESET  = 16'hF001;

    // Register indexes of the configuration port.
    localparam logic CFG_STATION = 1'b0;
    localparam logic CFG_MASTER  = 1'b1;

    // Header runs from SOH through the second version byte.
    localparam logic [4:0] HEAD_LEN = 5'd10;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [7:0] cmd;
        logic [1:0] plen;
        logic [7:0] pay0;
        logic [7:0] pay1;
        logic [7:0] pay2;
    } t_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_back_state;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        logic        mix;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c = {1'b0, c[15:1]};
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// File: rtl/sbrf_front.sv
`timescale 1ns / 1ps

module sbrf_front (
    input  logic              i_valid,
    input  logic [3:0]        i_operation,
    input  logic [15:0]       i_item_number,
    input  sbrf_pkg::t_q_status i_q_status,
    output logic              o_stall,
    output logic              o_push,
    output sbrf_pkg::t_req    o_req
);

    logic known;

    always_comb begin
        known      = 1'b1;
        o_req.cmd  = sbrf_pkg::CMD_VERSION;
        o_req.plen = 2'd0;
        o_req.pay0 = i_item_number[7:0];
        o_req.pay1 = i_item_number[15:8];
        o_req.pay2 = i_item_number[15:8];
        case (i_operation) inside
            sbrf_pkg::OP_VERSION: begin
                o_req.cmd = sbrf_pkg::CMD_VERSION;
            end
            [sbrf_pkg::OP_INFO_FIRST:sbrf_pkg::OP_INFO_LAST]: begin
                o_req.cmd  = sbrf_pkg::CMD_INFO;
                o_req.plen = 2'd1;
                o_req.pay0 = sbrf_pkg::INFO_BASE + {4'd0, i_operation};
            end
            sbrf_pkg::OP_BLOCK_CHANS: begin
                o_req.cmd  = sbrf_pkg::CMD_INFO;
                o_req.plen = 2'd2;
                o_req.pay0 = sbrf_pkg::SUB_BLOCK;
                o_req.pay1 = i_item_number[7:0];
            end
            sbrf_pkg::OP_CHAN_INFO: begin
                o_req.cmd  = sbrf_pkg::CMD_INFO;
                o_req.plen = 2'd3;
                o_req.pay0 = sbrf_pkg::SUB_CHAN_INFO;
                o_req.pay1 = i_item_number[7:0];
                o_req.pay2 = i_item_number[15:8];
            end
            sbrf_pkg::OP_ONLINE_ONE: begin
                o_req.cmd  = sbrf_pkg::CMD_ONLINE_ONE;
                o_req.plen = 2'd2;
            end
            sbrf_pkg::OP_ONLINE_MULT: begin
                o_req.cmd = sbrf_pkg::CMD_ONLINE_MULT;
            end
            sbrf_pkg::OP_RESET: begin
                o_req.cmd  = sbrf_pkg::CMD_RESET;
                o_req.plen = 2'd1;
                o_req.pay0 = sbrf_pkg::SUB_RESET;
            end
            sbrf_pkg::OP_STATUS: begin
                o_req.cmd = sbrf_pkg::CMD_STATUS;
            end
            sbrf_pkg::OP_ERROR: begin
                o_req.cmd = sbrf_pkg::CMD_ERROR;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown operations are accepted and dropped without touching the queue.
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full && known;

endmodule

// File: rtl/sbrf_queue.sv
`timescale 1ns / 1ps

module sbrf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sbrf_pkg::t_req      i_req,
    input  logic                i_pop,
    output sbrf_pkg::t_req      o_req,
    output sbrf_pkg::t_q_status o_status
);

    sbrf_pkg::t_req r_mem [sbrf_pkg::Q_DEPTH];
    logic [sbrf_pkg::Q_AW-1:0] r_wp, n_wp;
    logic [sbrf_pkg::Q_AW-1:0] r_rp, n_rp;
    logic [sbrf_pkg::Q_AW:0]   r_cnt, n_cnt;
    logic do_push;
    logic do_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == (sbrf_pkg::Q_AW+1)'(sbrf_pkg::Q_DEPTH));
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_req   = r_mem[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/sbrf_back.sv
`timescale 1ns / 1ps

module sbrf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_station,
    input  logic [15:0]         i_master,
    input  sbrf_pkg::t_req      i_req,
    input  sbrf_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_frame_byte,
    output logic                o_last_byte
);

    sbrf_pkg::t_back_state r_state, n_state;
    sbrf_pkg::t_req        r_req;
    logic [4:0]            r_pos;
    logic [15:0]           r_crc;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;

    logic       advance;
    logic [4:0] rel;
    logic [7:0] cur_byte;
    logic       cur_crc;
    logic       cur_last;

    assign rel = r_pos - sbrf_pkg::HEAD_LEN;

    // Byte at the current position; rel counts from the first payload byte.
    always_comb begin
        cur_byte = sbrf_pkg::EOT_BYTE;
        cur_crc  = 1'b0;
        cur_last = 1'b0;
        if (r_pos < sbrf_pkg::HEAD_LEN) begin
            cur_crc = 1'b1;
            case (r_pos)
                5'd0:    cur_byte = sbrf_pkg::SOH_BYTE;
                5'd1:    cur_byte = sbrf_pkg::VER_BYTE;
                5'd2:    cur_byte = i_station[7:0];
                5'd3:    cur_byte = i_station[15:8];
                5'd4:    cur_byte = i_master[7:0];
                5'd5:    cur_byte = i_master[15:8];
                5'd6:    cur_byte = 8'd2 + {6'd0, r_req.plen};
                5'd7:    cur_byte = sbrf_pkg::STX_BYTE;
                5'd8:    cur_byte = r_req.cmd;
                default: cur_byte = sbrf_pkg::VER_BYTE;
            endcase
        end else if (rel < {3'd0, r_req.plen}) begin
            cur_crc = 1'b1;
            case (rel[1:0])
                2'd0:    cur_byte = r_req.pay0;
                2'd1:    cur_byte = r_req.pay1;
                default: cur_byte = r_req.pay2;
            endcase
        end else if (rel == {3'd0, r_req.plen}) begin
            cur_crc  = 1'b1;
            cur_byte = sbrf_pkg::ETX_BYTE;
        end else if (rel == {3'd0, r_req.plen} + 5'd1) begin
            cur_byte = r_crc[7:0];
        end else if (rel == {3'd0, r_req.plen} + 5'd2) begin
            cur_byte = r_crc[15:8];
        end else begin
            cur_byte = sbrf_pkg::EOT_BYTE;
            cur_last = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbrf_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = sbrf_pkg::ST_SEND;
                end
            end
            sbrf_pkg::ST_SEND: begin
                if (advance && cur_last) begin
                    n_state = sbrf_pkg::ST_IDLE;
                end
            end
            default: n_state = sbrf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        advance = 1'b0;
        case (r_state)
            sbrf_pkg::ST_IDLE: o_pop = !i_q_status.empty;
            sbrf_pkg::ST_SEND: advance = !r_out_valid || !i_stall;
            default: begin
                o_pop   = 1'b0;
                advance = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbrf_pkg::ST_IDLE;
            r_pos       <= '0;
            r_crc       <= sbrf_pkg::CRC_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_pos <= '0;
                r_crc <= sbrf_pkg::CRC_START;
            end else if (advance) begin
                r_pos <= r_pos + 5'd1;
                if (cur_crc) begin
                    r_crc <= sbrf_pkg::crc_update(r_crc, cur_byte);
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

endmodule

// File: rtl/sensor_bus_request_framer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_operation[3:0], i_item_number[15:0]
// frame     out        o_valid / i_stall    o_frame_byte[7:0], o_last_byte
// config    in         i_cfg_we             i_cfg_index, i_cfg_data[15:0]
//
// A request becomes a frame of 14 to 17 bytes, one byte per cycle from the back
// sequencer unless the frame side stalls; it goes idle to load each request.
// A two-entry request queue lets the input keep accepting while a frame is
// sent. Reset empties the queue and restores both addresses. A stall on the
// frame side holds the output register and the sequencer.

module sensor_bus_request_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_operation,
    input  logic [15:0] i_item_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_station;
    logic [15:0] r_master;

    sbrf_pkg::t_req      front_req;
    sbrf_pkg::t_req      queue_req;
    sbrf_pkg::t_q_status q_status;
    logic                push;
    logic                pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= sbrf_pkg::STATION_RESET;
            r_master  <= sbrf_pkg::MASTER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbrf_pkg::CFG_STATION: r_station <= i_cfg_data;
                sbrf_pkg::CFG_MASTER:  r_master  <= i_cfg_data;
                default:               r_station <= r_station;
            endcase
        end
    end

    sbrf_front u_front (
        .i_valid       (i_valid),
        .i_operation   (i_operation),
        .i_item_number (i_item_number),
        .i_q_status    (q_status),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_req         (front_req)
    );

    sbrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (front_req),
        .i_pop    (pop),
        .o_req    (queue_req),
        .o_status (q_status)
    );

    sbrf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_station    (r_station),
        .i_master     (r_master),
        .i_req        (queue_req),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
